/* src/vrc6_pkg.sv */
// ============================================================================
// VRC6 mapper package
// Item kinds, result kinds, register indexes and decode constants shared by
// the bank mapper and scanline IRQ block.
// ============================================================================
package vrc6_pkg;

  // Bank count limits; masks follow from them.
  localparam int PRG_BANKS_MAX = 256;
  localparam int CHR_BANKS_MAX = 256;
  localparam logic [7:0] PRG_MAX_MASK = 8'(PRG_BANKS_MAX - 1);
  localparam logic [7:0] CHR_MAX_MASK = 8'(CHR_BANKS_MAX - 1);

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_TICK   = 2'd1,
    REQ_CPU_RD = 2'd2,
    REQ_PPU_RD = 2'd3
  } req_type_t;

  typedef enum logic [2:0] {
    MAP_NONE    = 3'd0,
    MAP_PRG_ROM = 3'd1,
    MAP_CHR_ROM = 3'd2,
    MAP_CHR_RAM = 3'd3,
    MAP_NT_RAM  = 3'd4
  } map_kind_t;

  typedef enum logic [1:0] {
    MIR_VERT   = 2'd0,
    MIR_HORZ   = 2'd1,
    MIR_ONE_LO = 2'd2,
    MIR_ONE_HI = 2'd3
  } mirror_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_PRG_MASK    = 2'd0;
  localparam logic [1:0] CFG_CHR_MASK    = 2'd1;
  localparam logic [1:0] CFG_CHR_PRESENT = 2'd2;

  localparam logic [7:0] PRG_MASK_RST = 8'd15;
  localparam logic [7:0] CHR_MASK_RST = 8'd127;

  // CPU register addresses.
  localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;
  localparam logic [15:0] ADDR_PRG_16K  = 16'h8000;
  localparam logic [15:0] ADDR_MIRROR   = 16'hB003;
  localparam logic [15:0] ADDR_PRG_8K   = 16'hC000;
  localparam logic [15:0] ADDR_CHR_LO   = 16'hD000;
  localparam logic [15:0] ADDR_CHR_HI   = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_LAT  = 16'hF000;
  localparam logic [15:0] ADDR_IRQ_ACK  = 16'hF001;
  localparam logic [15:0] ADDR_IRQ_CTL  = 16'hF002;
  localparam logic [15:0] ADDR_GRP_MASK = 16'hFFFC;

  // Mirroring data codes after the 7-bit mask.
  localparam logic [7:0] MIR_DATA_MASK = 8'h7F;
  localparam logic [7:0] MIR_CODE_HI_A = 8'h08;
  localparam logic [7:0] MIR_CODE_HI_B = 8'h2C;
  localparam logic [7:0] MIR_CODE_VERT = 8'h20;
  localparam logic [7:0] MIR_CODE_HORZ = 8'h24;
  localparam logic [7:0] MIR_CODE_LO   = 8'h28;

  localparam logic [7:0] IRQ_FIRE_LEVEL = 8'hFE;
  localparam logic [1:0] IRQ_EN_MASK    = 2'h3;
  localparam logic [7:0] LAST_PRG_BANK  = 8'hFF;

  // PPU palette window starts at 0x3F00 (upper six bits of the 14-bit address).
  localparam logic [5:0] PPU_PALETTE_HI = 6'h3F;

endpackage

/* src/vrc6_bank_and_scanline_irq.sv */
// ============================================================================
// VRC6 bank mapper and scanline IRQ
// Bank registers, mirroring, scanline IRQ counter, sound write forwarding
// and CPU/PPU address translation in a two-register pipeline.
// ============================================================================
//
// This block accepts one beat per clock on the input channel while the
// output is not stalled, and returns exactly one result beat for every input
// beat. The beat is captured in the input register at the edge that accepts
// it. When the input register moves on, all decoding, state update and
// translation happen in one pass of short logic into the result register,
// which offers the result beat. The input register moves on whenever the
// result register is empty or is being emptied in the same cycle, so with
// out_ready held high a new beat is taken every clock. A stall on the output
// holds the result register; the input register still takes one beat if it
// is empty, and once both registers are full in_ready drops until the result
// beat is taken. Mapper state (bank slots, mirroring, IRQ reload value,
// counter and enable) is updated at the moment an item moves into the result
// register, so every item sees the effect of all items before it.
// Configuration writes are always accepted (cfg_ready is high) and must be
// made only while no items are in flight. An index beyond the three
// configuration registers is ignored.
module vrc6_bank_and_scanline_irq (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [15:0] in_bus_addr,
  input  logic [7:0]  in_wr_data,
  // Result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_irq_pulse,
  output logic        out_snd_write,
  output logic [15:0] out_snd_addr,
  output logic [7:0]  out_snd_data,
  output logic [2:0]  out_map_kind,
  output logic [20:0] out_map_offset,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] prg_mask_r;
  logic [7:0] chr_mask_r;
  logic       chr_present_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r    <= vrc6_pkg::PRG_MASK_RST;
      chr_mask_r    <= vrc6_pkg::CHR_MASK_RST;
      chr_present_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vrc6_pkg::CFG_PRG_MASK:    prg_mask_r    <= cfg_data;
        vrc6_pkg::CFG_CHR_MASK:    chr_mask_r    <= cfg_data;
        vrc6_pkg::CFG_CHR_PRESENT: chr_present_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake
  // --------------------------------------------------------------------------
  logic                item_valid_r;
  vrc6_pkg::req_type_t item_type_r;
  logic [15:0]         item_addr_r;
  logic [7:0]          item_data_r;
  logic                out_valid_r;
  logic                advance;

  // The input register moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_type_r <= vrc6_pkg::req_type_t'(in_req_type);
      item_addr_r <= in_bus_addr;
      item_data_r <= in_wr_data;
    end
  end

  // --------------------------------------------------------------------------
  // Mapper state
  // --------------------------------------------------------------------------
  logic [7:0]        prg_slot_r [3];
  logic [7:0]        chr_slot_r [8];
  vrc6_pkg::mirror_t mirror_r;
  logic [7:0]        irq_reload_r;
  logic [7:0]        irq_count_r;
  logic [1:0]        irq_enable_r;

  logic [7:0]        prg_slot_nxt [3];
  logic [7:0]        chr_slot_nxt [8];
  vrc6_pkg::mirror_t mirror_nxt;
  logic [7:0]        irq_count_nxt;
  logic [7:0]        irq_reload_nxt;
  logic [1:0]        irq_enable_nxt;

  // Result fields computed from the input register.
  logic                 irq_pulse_nxt;
  logic                 snd_write_nxt;
  logic [15:0]          snd_addr_nxt;
  logic [7:0]           snd_data_nxt;
  vrc6_pkg::map_kind_t  map_kind_nxt;
  logic [20:0]          map_offset_nxt;

  logic [7:0]  wr_masked;
  logic [7:0]  prg_bank;
  logic [7:0]  chr_bank;
  logic [13:0] ppu_addr;
  logic        irq_fire;
  logic        do_step;

  assign do_step   = item_valid_r && advance;
  assign wr_masked = item_data_r & vrc6_pkg::MIR_DATA_MASK;
  assign ppu_addr  = item_addr_r[13:0];
  assign irq_fire  = irq_count_r >= vrc6_pkg::IRQ_FIRE_LEVEL;

  // The top 8 KiB window always maps the last bank; the other three windows
  // come from the slots, indexed by the window number.
  always_comb begin
    if (item_addr_r[14:13] == 2'd3) begin
      prg_bank = vrc6_pkg::LAST_PRG_BANK;
    end else begin
      prg_bank = prg_slot_r[item_addr_r[14:13]];
    end
    prg_bank = prg_bank & prg_mask_r & vrc6_pkg::PRG_MAX_MASK;
    chr_bank = chr_slot_r[ppu_addr[12:10]] & chr_mask_r & vrc6_pkg::CHR_MAX_MASK;
  end

  always_comb begin
    prg_slot_nxt   = prg_slot_r;
    chr_slot_nxt   = chr_slot_r;
    mirror_nxt     = mirror_r;
    irq_reload_nxt = irq_reload_r;
    irq_count_nxt  = irq_count_r;
    irq_enable_nxt = irq_enable_r;

    irq_pulse_nxt  = 1'b0;
    snd_write_nxt  = 1'b0;
    snd_addr_nxt   = '0;
    snd_data_nxt   = '0;
    map_kind_nxt   = vrc6_pkg::MAP_NONE;
    map_offset_nxt = '0;

    unique case (item_type_r)
      vrc6_pkg::REQ_WRITE: begin
        if (item_addr_r[15]) begin
          // Every write in the ROM area goes to the sound unit, with the
          // two low address bits exchanged.
          snd_write_nxt = 1'b1;
          snd_addr_nxt  = {item_addr_r[15:2], item_addr_r[0], item_addr_r[1]};
          snd_data_nxt  = item_data_r;
          if (item_addr_r == vrc6_pkg::ADDR_PRG_16K) begin
            prg_slot_nxt[0] = {item_data_r[6:0], 1'b0};
            prg_slot_nxt[1] = {item_data_r[6:0], 1'b1};
          end else if (item_addr_r == vrc6_pkg::ADDR_MIRROR) begin
            snd_data_nxt = wr_masked;
            unique case (wr_masked)
              vrc6_pkg::MIR_CODE_HI_A: mirror_nxt = vrc6_pkg::MIR_ONE_HI;
              vrc6_pkg::MIR_CODE_HI_B: mirror_nxt = vrc6_pkg::MIR_ONE_HI;
              vrc6_pkg::MIR_CODE_VERT: mirror_nxt = vrc6_pkg::MIR_VERT;
              vrc6_pkg::MIR_CODE_HORZ: mirror_nxt = vrc6_pkg::MIR_HORZ;
              vrc6_pkg::MIR_CODE_LO:   mirror_nxt = vrc6_pkg::MIR_ONE_LO;
              default: ;
            endcase
          end else if (item_addr_r == vrc6_pkg::ADDR_PRG_8K) begin
            prg_slot_nxt[2] = item_data_r;
          end else if ((item_addr_r & vrc6_pkg::ADDR_GRP_MASK) == vrc6_pkg::ADDR_CHR_LO) begin
            // Register order within the group is 0, 2, 1, 3.
            chr_slot_nxt[{1'b0, item_addr_r[0], item_addr_r[1]}] = item_data_r;
          end else if ((item_addr_r & vrc6_pkg::ADDR_GRP_MASK) == vrc6_pkg::ADDR_CHR_HI) begin
            chr_slot_nxt[{1'b1, item_addr_r[0], item_addr_r[1]}] = item_data_r;
          end else if (item_addr_r == vrc6_pkg::ADDR_IRQ_LAT) begin
            irq_reload_nxt = item_data_r;
          end else if (item_addr_r == vrc6_pkg::ADDR_IRQ_ACK) begin
            irq_enable_nxt = {1'b0, item_data_r[0]};
          end else if (item_addr_r == vrc6_pkg::ADDR_IRQ_CTL) begin
            irq_enable_nxt = item_data_r[1:0] & vrc6_pkg::IRQ_EN_MASK;
            if (item_data_r[1]) begin
              irq_count_nxt = irq_reload_r;
            end
          end
        end
      end
      vrc6_pkg::REQ_TICK: begin
        if (irq_enable_r != 2'd0) begin
          if (irq_fire) begin
            irq_pulse_nxt  = 1'b1;
            irq_count_nxt  = irq_reload_r;
            irq_enable_nxt = 2'd0;
          end else begin
            irq_count_nxt = irq_count_r + 8'd1;
          end
        end
      end
      vrc6_pkg::REQ_CPU_RD: begin
        if (item_addr_r[15]) begin
          map_kind_nxt   = vrc6_pkg::MAP_PRG_ROM;
          map_offset_nxt = {prg_bank, item_addr_r[12:0]};
        end
      end
      vrc6_pkg::REQ_PPU_RD: begin
        if (!ppu_addr[13]) begin
          // Pattern tables: banked ROM, or flat 8 KiB RAM.
          if (chr_present_r) begin
            map_kind_nxt   = vrc6_pkg::MAP_CHR_ROM;
            map_offset_nxt = {3'd0, chr_bank, ppu_addr[9:0]};
          end else begin
            map_kind_nxt   = vrc6_pkg::MAP_CHR_RAM;
            map_offset_nxt = {8'd0, ppu_addr[12:0]};
          end
        end else if (ppu_addr[13:8] != vrc6_pkg::PPU_PALETTE_HI) begin
          // Nametables fold into 2 KiB by the mirroring mode.
          map_kind_nxt = vrc6_pkg::MAP_NT_RAM;
          unique case (mirror_r)
            vrc6_pkg::MIR_VERT:   map_offset_nxt = {10'd0, ppu_addr[10:0]};
            vrc6_pkg::MIR_HORZ:   map_offset_nxt = {10'd0, ppu_addr[11], ppu_addr[9:0]};
            vrc6_pkg::MIR_ONE_LO: map_offset_nxt = {10'd0, 1'b0, ppu_addr[9:0]};
            vrc6_pkg::MIR_ONE_HI: map_offset_nxt = {10'd0, 1'b1, ppu_addr[9:0]};
            default:              map_offset_nxt = '0;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_slot_r[0] <= 8'd0;
      prg_slot_r[1] <= 8'd1;
      prg_slot_r[2] <= 8'd254;
      for (int i = 0; i < 8; i++) begin
        chr_slot_r[i] <= 8'(i);
      end
      mirror_r     <= vrc6_pkg::MIR_VERT;
      irq_reload_r <= 8'd0;
      irq_count_r  <= 8'd0;
      irq_enable_r <= 2'd0;
    end else if (do_step) begin
      prg_slot_r   <= prg_slot_nxt;
      chr_slot_r   <= chr_slot_nxt;
      mirror_r     <= mirror_nxt;
      irq_reload_r <= irq_reload_nxt;
      irq_count_r  <= irq_count_nxt;
      irq_enable_r <= irq_enable_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic                irq_pulse_r;
  logic                snd_write_r;
  logic [15:0]         snd_addr_r;
  logic [7:0]          snd_data_r;
  vrc6_pkg::map_kind_t map_kind_r;
  logic [20:0]         map_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (do_step) begin
      irq_pulse_r  <= irq_pulse_nxt;
      snd_write_r  <= snd_write_nxt;
      snd_addr_r   <= snd_addr_nxt;
      snd_data_r   <= snd_data_nxt;
      map_kind_r   <= map_kind_nxt;
      map_offset_r <= map_offset_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_irq_pulse  = irq_pulse_r;
  assign out_snd_write  = snd_write_r;
  assign out_snd_addr   = snd_addr_r;
  assign out_snd_data   = snd_data_r;
  assign out_map_kind   = map_kind_r;
  assign out_map_offset = map_offset_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A tick that fires leaves the IRQ disarmed.
  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (do_step && item_type_r == vrc6_pkg::REQ_TICK && irq_enable_r != 2'd0 && irq_fire)
    |=> (irq_enable_r == 2'd0 && out_irq_pulse))
    else $error("IRQ fired without clearing the enable");

  // An interrupt result carries no translation and no sound write.
  a_irq_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_pulse)
    |-> (!out_snd_write && out_map_kind == vrc6_pkg::MAP_NONE))
    else $error("IRQ result mixed with other fields");

  // Nametable offsets stay inside 2 KiB.
  a_nt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_map_kind == vrc6_pkg::MAP_NT_RAM) |-> (out_map_offset[20:11] == 10'd0))
    else $error("nametable offset out of range");

  // A held input item stays in the input register until it moves on.
  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    (item_valid_r && !advance) |=> (item_valid_r && $stable(item_addr_r)))
    else $error("input register lost a stalled item");

  // The mirroring register write always forwards 7-bit data.
  a_mirror_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_snd_write && out_snd_addr == vrc6_pkg::ADDR_MIRROR)
    |-> !out_snd_data[7])
    else $error("mirroring write forwarded unmasked data");

endmodule

/* tb/vrc6_mapper_sb_pkg.sv */
`timescale 1ns / 1ps
// ============================================================================
// VRC6 mapper scoreboard
// Keeps a shadow copy of the mapper state and configuration, predicts the
// result beat for every accepted input beat, and compares the returned
// beats field by field in order.
// ============================================================================
package vrc6_mapper_sb_pkg;
  import vrc6_pkg::*;

  // Field order matches the concatenation of the result ports.
  typedef struct packed {
    logic        irq_pulse;
    logic        snd_write;
    logic [15:0] snd_addr;
    logic [7:0]  snd_data;
    map_kind_t   kind;
    logic [20:0] offset;
  } mapper_result_t;

  class vrc6_mapper_scoreboard;
    logic [7:0]     prg_mask;
    logic [7:0]     chr_mask;
    logic           chr_rom;
    logic [7:0]     prg_slot [3];
    logic [7:0]     chr_slot [8];
    mirror_t        mirror;
    logic [7:0]     irq_reload;
    logic [7:0]     irq_count;
    logic [1:0]     irq_enable;
    mapper_result_t expected_q [$];
    int             mismatches;

    function new();
      prg_mask    = PRG_MASK_RST;
      chr_mask    = CHR_MASK_RST;
      chr_rom     = 1'b1;
      prg_slot[0] = 8'd0;
      prg_slot[1] = 8'd1;
      prg_slot[2] = 8'd254;
      for (int i = 0; i < 8; i++) chr_slot[i] = 8'(i);
      mirror      = MIR_VERT;
      irq_reload  = 8'd0;
      irq_count   = 8'd0;
      irq_enable  = 2'd0;
      mismatches  = 0;
    endfunction

    function void set_register(logic [1:0] index, logic [7:0] value);
      case (index)
        CFG_PRG_MASK:    prg_mask = value;
        CFG_CHR_MASK:    chr_mask = value;
        CFG_CHR_PRESENT: chr_rom  = value[0];
        default: ;
      endcase
    endfunction

    // Applies one accepted beat to the shadow state and queues its result.
    function void note_request(req_type_t req, logic [15:0] a, logic [7:0] d);
      mapper_result_t r;
      logic [7:0]     sd;
      logic [7:0]     bank;
      logic [13:0]    p;
      logic [10:0]    nt_off;
      r = '0;
      case (req)
        REQ_WRITE: begin
          if (a >= ADDR_ROM_BASE) begin
            sd = d;
            if (a == ADDR_PRG_16K) begin
              prg_slot[0] = {d[6:0], 1'b0};
              prg_slot[1] = {d[6:0], 1'b1};
            end else if (a == ADDR_MIRROR) begin
              sd = d & MIR_DATA_MASK;
              if (sd == MIR_CODE_HI_A || sd == MIR_CODE_HI_B) mirror = MIR_ONE_HI;
              else if (sd == MIR_CODE_VERT) mirror = MIR_VERT;
              else if (sd == MIR_CODE_HORZ) mirror = MIR_HORZ;
              else if (sd == MIR_CODE_LO) mirror = MIR_ONE_LO;
            end else if (a == ADDR_PRG_8K) begin
              prg_slot[2] = d;
            end else if ((a & ADDR_GRP_MASK) == ADDR_CHR_LO) begin
              // Slot order within a group is 0, 2, 1, 3: address bits swapped.
              chr_slot[{1'b0, a[0], a[1]}] = d;
            end else if ((a & ADDR_GRP_MASK) == ADDR_CHR_HI) begin
              chr_slot[{1'b1, a[0], a[1]}] = d;
            end else if (a == ADDR_IRQ_LAT) begin
              irq_reload = d;
            end else if (a == ADDR_IRQ_ACK) begin
              irq_enable = {1'b0, d[0]};
            end else if (a == ADDR_IRQ_CTL) begin
              irq_enable = d[1:0] & IRQ_EN_MASK;
              if (irq_enable[1]) irq_count = irq_reload;
            end
            r.snd_write = 1'b1;
            r.snd_addr  = {a[15:2], a[0], a[1]};
            r.snd_data  = sd;
          end
        end
        REQ_TICK: begin
          if (irq_enable != 2'd0) begin
            if (irq_count >= IRQ_FIRE_LEVEL) begin
              r.irq_pulse = 1'b1;
              irq_count   = irq_reload;
              irq_enable  = 2'd0;
            end else begin
              irq_count = irq_count + 8'd1;
            end
          end
        end
        REQ_CPU_RD: begin
          if (a >= ADDR_ROM_BASE) begin
            // The top 8 KiB window is hard-wired to the last bank.
            bank     = (a[15:13] == 3'b111) ? LAST_PRG_BANK : prg_slot[a[14:13]];
            bank     = bank & prg_mask & PRG_MAX_MASK;
            r.kind   = MAP_PRG_ROM;
            r.offset = {bank, a[12:0]};
          end
        end
        default: begin
          p = a[13:0];
          if (!p[13]) begin
            if (chr_rom) begin
              bank     = chr_slot[p[12:10]] & chr_mask & CHR_MAX_MASK;
              r.kind   = MAP_CHR_ROM;
              r.offset = {3'b000, bank, p[9:0]};
            end else begin
              r.kind   = MAP_CHR_RAM;
              r.offset = {8'd0, p[12:0]};
            end
          end else if (p[13:8] != PPU_PALETTE_HI) begin
            case (mirror)
              MIR_VERT:   nt_off = p[10:0];
              MIR_HORZ:   nt_off = {p[11], p[9:0]};
              MIR_ONE_LO: nt_off = {1'b0, p[9:0]};
              default:    nt_off = {1'b1, p[9:0]};
            endcase
            r.kind   = MAP_NT_RAM;
            r.offset = {10'd0, nt_off};
          end
        end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_field(string name, logic [20:0] want, logic [20:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_result(mapper_result_t got);
      mapper_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, actual 0x%0h", $time, got);
        return;
      end
      want = expected_q.pop_front();
      check_field("irq_pulse", 21'(want.irq_pulse), 21'(got.irq_pulse));
      check_field("snd_write", 21'(want.snd_write), 21'(got.snd_write));
      check_field("snd_addr", 21'(want.snd_addr), 21'(got.snd_addr));
      check_field("snd_data", 21'(want.snd_data), 21'(got.snd_data));
      check_field("map_kind", 21'(want.kind), 21'(got.kind));
      check_field("map_offset", want.offset, got.offset);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// VRC6 bank mapper and scanline IRQ testbench
// Drives bus writes, scanline ticks and CPU/PPU read translations through
// the valid/ready input channel under random bursts and output stalls, runs
// several configuration settings, and checks every result beat against a
// scoreboard that tracks the mapper state.
// ============================================================================
module tb_top;
  import vrc6_pkg::*;
  import vrc6_mapper_sb_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = 2'd0;
  logic [15:0] in_bus_addr = 16'd0;
  logic [7:0]  in_wr_data = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_irq_pulse;
  logic        out_snd_write;
  logic [15:0] out_snd_addr;
  logic [7:0]  out_snd_data;
  logic [2:0]  out_map_kind;
  logic [20:0] out_map_offset;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [7:0]  cfg_data = 8'd0;

  mapper_result_t        observed;
  vrc6_mapper_scoreboard sb = new();

  // Sender burst bookkeeping.
  int burst_left = 1;

  // Receiver stall state: a random mode that is redrawn when its count runs out,
  // plus a periodic long hold-off that backs the block up into its input.
  int ready_mode = 0;
  int mode_left = 0;
  int since_hold = 0;
  int hold_left = 0;
  int pattern_cnt = 0;

  always #5 clk = ~clk;

  vrc6_bank_and_scanline_irq i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_bus_addr   (in_bus_addr),
    .in_wr_data    (in_wr_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_irq_pulse (out_irq_pulse),
    .out_snd_write (out_snd_write),
    .out_snd_addr  (out_snd_addr),
    .out_snd_data  (out_snd_data),
    .out_map_kind  (out_map_kind),
    .out_map_offset(out_map_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The result ports packed in the same order as the scoreboard's struct.
  assign observed = {out_irq_pulse, out_snd_write, out_snd_addr, out_snd_data,
                     out_map_kind, out_map_offset};

  // Result monitor. Sampling at the clock edge sees the values that were
  // stable before the edge, so the handshake is judged the same way the
  // block judges it.
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_result(observed);
  end

  // Receiver. Every branch makes exactly one assignment to out_ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      since_hold++;
      pattern_cnt++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (since_hold >= 400 && in_valid) begin
        // Long hold-off while the sender is offering beats: the pipeline
        // fills and in_ready has to drop.
        hold_left  = 120;
        since_hold = 0;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = $urandom_range(0, 3);
          mode_left  = $urandom_range(20, 100);
        end else begin
          mode_left--;
        end
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (pattern_cnt % 7 != 3) && (pattern_cnt % 5 != 0);
        endcase
      end
    end
  end

  // Offers one beat and holds it until it is accepted. When a burst runs
  // out, valid drops for a random gap; a zero gap keeps valid high so that
  // the next beat follows back to back.
  task automatic send_item(req_type_t req, logic [15:0] addr, logic [7:0] data);
    int gap;
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_bus_addr <= addr;
    in_wr_data  <= data;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_request(req, addr, data);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Writes all three configuration registers as consecutive beats, keeping
  // valid high between them.
  task automatic write_config(logic [7:0] prg_mask, logic [7:0] chr_mask, logic present);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    idx[0] = CFG_PRG_MASK;
    idx[1] = CFG_CHR_MASK;
    idx[2] = CFG_CHR_PRESENT;
    val[0] = prg_mask;
    val[1] = chr_mask;
    val[2] = {7'd0, present};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      sb.set_register(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Stops offering and waits until every expected result has come back,
  // then lets the two pipeline stages settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mirroring data: mostly the meaningful codes, with bit 7 set at random to
  // exercise the 7-bit mask, and sometimes an arbitrary byte.
  function automatic logic [7:0] mirror_byte();
    logic [7:0] b;
    case ($urandom_range(0, 6))
      0:       b = MIR_CODE_HI_A;
      1:       b = MIR_CODE_HI_B;
      2:       b = MIR_CODE_VERT;
      3:       b = MIR_CODE_HORZ;
      4:       b = MIR_CODE_LO;
      default: return 8'($urandom_range(0, 255));
    endcase
    return b | {1'($urandom_range(0, 1)), 7'd0};
  endfunction

  // One random beat. Writes go mostly to real register addresses so that
  // the banks, mirroring and IRQ logic see plenty of traffic; the reload
  // value is biased high so that reloads bring the counter near its firing
  // level.
  task automatic send_random_item();
    int         pick;
    logic [15:0] a;
    logic [7:0]  d;
    a    = 16'($urandom_range(0, 65535));
    d    = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 9))
        0: a = ADDR_PRG_16K;
        1: begin
          a = ADDR_MIRROR;
          d = mirror_byte();
        end
        2: a = ADDR_PRG_8K;
        3: a = ADDR_CHR_LO | 16'($urandom_range(0, 3));
        4: a = ADDR_CHR_HI | 16'($urandom_range(0, 3));
        5: begin
          a = ADDR_IRQ_LAT;
          if ($urandom_range(0, 1) == 1) d = {4'hF, 4'($urandom_range(0, 15))};
        end
        6: a = ADDR_IRQ_ACK;
        7: a = ADDR_IRQ_CTL;
        default: ;
      endcase
      send_item(REQ_WRITE, a, d);
    end else if (pick < 70) begin
      send_item(REQ_TICK, a, d);
    end else if (pick < 85) begin
      if ($urandom_range(0, 3) != 0) a[15] = 1'b1;
      send_item(REQ_CPU_RD, a, d);
    end else begin
      send_item(REQ_PPU_RD, a, d);
    end
  endtask

  // Directed opening: an ignored low write, the wrapping 16 KiB bank write,
  // every mirroring code including masked and meaningless data, an IRQ that
  // fires from a reloaded counter, and the address extremes of both reads.
  task automatic directed_items();
    send_item(REQ_WRITE, 16'h7FFF, 8'hAA);
    send_item(REQ_WRITE, ADDR_PRG_16K, 8'hFF);
    send_item(REQ_WRITE, ADDR_PRG_8K, 8'h80);
    send_item(REQ_WRITE, ADDR_CHR_LO | 16'd1, 8'h05);
    send_item(REQ_WRITE, ADDR_CHR_HI | 16'd2, 8'hFF);
    send_item(REQ_WRITE, 16'h9001, 8'h12);
    send_item(REQ_WRITE, ADDR_MIRROR, MIR_CODE_HORZ | 8'h80);
    send_item(REQ_PPU_RD, 16'h2C00, 8'h00);
    send_item(REQ_WRITE, ADDR_MIRROR, 8'h55);
    send_item(REQ_WRITE, ADDR_MIRROR, MIR_CODE_HI_A);
    send_item(REQ_PPU_RD, 16'h2400, 8'h00);
    send_item(REQ_WRITE, ADDR_MIRROR, MIR_CODE_LO);
    send_item(REQ_PPU_RD, 16'h2C00, 8'h00);
    send_item(REQ_WRITE, ADDR_MIRROR, MIR_CODE_HI_B);
    send_item(REQ_WRITE, ADDR_MIRROR, MIR_CODE_VERT);
    send_item(REQ_WRITE, ADDR_IRQ_LAT, IRQ_FIRE_LEVEL);
    send_item(REQ_WRITE, ADDR_IRQ_CTL, 8'h03);
    send_item(REQ_TICK, 16'h0000, 8'h00);
    send_item(REQ_TICK, 16'hFFFF, 8'hFF);
    send_item(REQ_WRITE, ADDR_IRQ_ACK, 8'hFF);
    send_item(REQ_TICK, 16'h0000, 8'h00);
    send_item(REQ_CPU_RD, 16'h0000, 8'h00);
    send_item(REQ_CPU_RD, ADDR_ROM_BASE, 8'h00);
    send_item(REQ_CPU_RD, 16'hDFFF, 8'h00);
    send_item(REQ_CPU_RD, 16'hFFFF, 8'h00);
    send_item(REQ_PPU_RD, 16'h0000, 8'h00);
    send_item(REQ_PPU_RD, 16'h3EFF, 8'h00);
    send_item(REQ_PPU_RD, 16'hFF00, 8'h00);
  endtask

  // Main sequence: directed and random beats on the reset configuration, then
  // more random phases, each under a new configuration written while idle.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_items();
    repeat (150) send_random_item();
    for (int phase = 1; phase <= 5; phase++) begin
      drain();
      case (phase)
        1: write_config(8'hFF, 8'hFF, 1'b1);
        2: write_config(8'h01, 8'h00, 1'b0);
        3: write_config(8'((1 << $urandom_range(1, 8)) - 1),
                        8'((1 << $urandom_range(0, 8)) - 1), 1'b1);
        4: write_config(8'hFF, 8'h00, 1'b1);
        default: write_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
      endcase
      repeat (150) send_random_item();
    end
    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
